// ----- hw/rtl/bble_pkg.sv -----
// Package for the byte-budget LRU evictor: widths, operation codes, load states.
// No dependencies.
package bble_pkg;
    localparam int ENTRIES_DEF    = 16;
    localparam int STAMP_BITS_DEF = 32;
    localparam int BYTE_W         = 48;
    localparam int TOTAL_W        = 52;
    localparam int ID_W           = 4;
    localparam int OP_W           = 3;
    localparam int LS_W           = 2;

    localparam logic [OP_W-1:0] OP_TOUCH   = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OP_W-1:0] OP_SETST   = 3'd2;
    localparam logic [OP_W-1:0] OP_ENFORCE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6   = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7   = 3'd7;

    localparam logic [LS_W-1:0] LS_UNLOADED = 2'd0;
    localparam logic [LS_W-1:0] LS_LOADING  = 2'd1;
    localparam logic [LS_W-1:0] LS_LOADED   = 2'd2;
    localparam logic [LS_W-1:0] LS_INVALID  = 2'd3;
endpackage

// ----- hw/rtl/bble_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module bble_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/byte_budget_lru_evictor.sv -----
// Byte-budget LRU evictor top level: entry table in RAM, scan-based victim search.
// Depends on bble_pkg and bble_ram.
//
//  channel  | direction | tdata fields (low bit up)                     | tuser | tlast
//  s_axis   | in        | operation, entry_id, byte_count, new_state    | -     | -
//  m_axis   | out       | kind, result_id, from, to, changed, total,over| -     | last
//  cfg      | in        | max_bytes (48 bit) on cfg_wdata, cfg_we       | -     | -
//
// A new operation is accepted only once the previous one is done and the output register
// is empty. Set_state with a valid new state answers straight from the check state; other
// operations answer through the ack state. Insert and enforce add a budget check; touch of
// a present entry and insert of a present one add a read-modify-write of its RAM word.
// Each eviction round reads every entry once from RAM, one read a cycle.
// Reset clears present bits, load states, total and stamp counter at once.
// A result waits in the output register; while it is held, input and new results stall.
module byte_budget_lru_evictor #(
    parameter int ENTRIES    = bble_pkg::ENTRIES_DEF,
    parameter int STAMP_BITS = bble_pkg::STAMP_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [47:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[2:0], entry_id[6:3], byte_count[54:7], new_state[56:55], zero fill
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // kind[0], result_id[4:1], from_state[6:5], to_state[8:7], state_changed[9],
    // total_bytes[61:10], over_budget[62], zero fill
    output logic [63:0]  m_axis_tdata,
    output logic         m_axis_tlast
);
    import bble_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int RW = BYTE_W + STAMP_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_EVICT = 3'd3;
    localparam logic [2:0] ST_ACK   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [47:0]           max_reg;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic [STAMP_BITS-1:0] cnt_reg, cnt_next;
    logic [ENTRIES-1:0]    pres_reg, pres_next;
    logic [LS_W-1:0]       ls_reg [ENTRIES];
    logic [LS_W-1:0]       ls_next [ENTRIES];

    logic [OP_W-1:0]   op_reg, op_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [BYTE_W-1:0] bc_reg, bc_next;
    logic [LS_W-1:0]   ns_reg, ns_next;
    logic              prot_reg, prot_next;

    logic [CW-1:0]     scan_reg, scan_next;
    logic              rvld_reg, rvld_next;
    logic [IW-1:0]     ridx_reg, ridx_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     vic_reg, vic_next;
    logic [STAMP_BITS-1:0] old_reg, old_next;
    logic [BYTE_W-1:0] vbytes_reg, vbytes_next;

    logic [63:0] out_reg, out_next;
    logic        ovld_reg, ovld_next;
    logic        olast_reg, olast_next;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [RW-1:0] wdata, rdata;

    bble_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_tab (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic          id_ok;
    logic [IW-1:0] idx;
    logic          over;
    logic [BYTE_W-1:0]     r_bytes;
    logic [STAMP_BITS-1:0] r_stamp;

    assign id_ok   = {{(32-ID_W){1'b0}}, id_reg} < ENTRIES;
    assign idx     = IW'(id_reg);
    assign over    = (max_reg != '0) && (total_reg > {4'd0, max_reg});
    assign r_bytes = rdata[BYTE_W-1:0];
    assign r_stamp = rdata[RW-1:BYTE_W];

    assign s_axis_tready = (state_reg == ST_IDLE) && !ovld_reg;
    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tlast  = olast_reg;

    function automatic logic [63:0] pack_res(
        input logic kind, input logic [ID_W-1:0] rid, input logic [LS_W-1:0] fs,
        input logic [LS_W-1:0] ts, input logic ch, input logic [TOTAL_W-1:0] tot,
        input logic ob);
        pack_res = {1'b0, ob, tot, ch, ts, fs, rid, kind};
    endfunction

    // sequencer
    always_comb begin
        logic [LS_W-1:0]    st;
        logic [TOTAL_W-1:0] t2;
        state_next = state_reg; total_next = total_reg; cnt_next = cnt_reg;
        pres_next = pres_reg; ls_next = ls_reg;
        op_next = op_reg; id_next = id_reg; bc_next = bc_reg; ns_next = ns_reg;
        prot_next = prot_reg; scan_next = scan_reg; rvld_next = 1'b0;
        ridx_next = ridx_reg; found_next = found_reg; vic_next = vic_reg;
        old_next = old_reg; vbytes_next = vbytes_reg;
        out_next = out_reg; olast_next = olast_reg;
        ovld_next = ovld_reg && !m_axis_tready;
        we = 1'b0; waddr = idx; wdata = {cnt_reg, bc_reg}; raddr = IW'(scan_reg);
        st = id_ok ? ls_reg[idx] : LS_UNLOADED;
        t2 = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    op_next = s_axis_tdata[2:0];
                    id_next = s_axis_tdata[6:3];
                    bc_next = s_axis_tdata[54:7];
                    ns_next = s_axis_tdata[56:55];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // apply the operation, then decide on eviction
                state_next = ST_ACK;
                prot_next = 1'b0;
                case (op_reg)
                    OP_TOUCH: begin
                        if (id_ok && pres_reg[idx]) begin
                            // bytes unchanged: read them back, then write the new stamp
                            cnt_next = cnt_reg + 1'b1;
                            state_next = ST_OUT;
                        end
                    end
                    OP_INSERT: begin
                        cnt_next = cnt_reg + 1'b1;
                        if (id_ok) begin
                            prot_next = 1'b1;
                            if (!pres_reg[idx]) begin
                                we = 1'b1;
                                pres_next[idx] = 1'b1;
                                total_next = total_reg + {4'd0, bc_reg};
                            end else begin
                                state_next = ST_OUT;
                            end
                        end else begin
                            cnt_next = cnt_reg;
                        end
                        if (state_next == ST_ACK) begin
                            state_next = ST_SCAN; scan_next = '0; found_next = 1'b0;
                        end
                    end
                    OP_SETST: begin
                        if (id_ok && ns_reg != LS_INVALID) begin
                            ls_next[idx] = ns_reg;
                            out_next = pack_res(1'b0, id_reg, ls_reg[idx], ns_reg,
                                ls_reg[idx] != ns_reg, total_reg, over);
                            olast_next = 1'b1;
                            state_next = ST_IDLE;
                            ovld_next = 1'b1;
                        end
                    end
                    OP_ENFORCE: begin
                        state_next = ST_SCAN; scan_next = '0; found_next = 1'b0;
                    end
                    OP_CLEAR: begin
                        pres_next = '0; total_next = '0;
                        for (int i = 0; i < ENTRIES; i++) ls_next[i] = LS_UNLOADED;
                    end
                    default: ;
                endcase
            end
            ST_OUT: begin
                // present entry restamped: read its bytes, write new stamp
                raddr = idx;
                if (!rvld_reg) begin
                    rvld_next = 1'b1;
                end else begin
                    we = 1'b1;
                    wdata = {cnt_reg - 1'b1, r_bytes};
                    if (op_reg == OP_INSERT) begin
                        state_next = ST_SCAN; scan_next = '0; found_next = 1'b0;
                    end else begin
                        state_next = ST_ACK;
                    end
                end
            end
            ST_SCAN: begin
                // one entry a cycle: issue read, compare returned data
                if (!(max_reg != '0 && total_reg > {4'd0, max_reg})) begin
                    state_next = ST_ACK;
                end else begin
                    if (scan_reg < CW'(ENTRIES)) begin
                        raddr = IW'(scan_reg);
                        rvld_next = 1'b1; ridx_next = IW'(scan_reg);
                        scan_next = scan_reg + 1'b1;
                    end
                    if (rvld_reg && pres_reg[ridx_reg] && ls_reg[ridx_reg] != LS_LOADING
                        && !(prot_reg && ridx_reg == idx)
                        && (!found_reg || r_stamp < old_reg)) begin
                        found_next = 1'b1; vic_next = ridx_reg;
                        old_next = r_stamp; vbytes_next = r_bytes;
                    end
                    if (scan_reg == CW'(ENTRIES) && !rvld_reg) begin
                        state_next = found_reg ? ST_EVICT : ST_ACK;
                    end
                end
            end
            ST_EVICT: begin
                if (!ovld_reg || m_axis_tready) begin
                    t2 = total_reg - {4'd0, vbytes_reg};
                    total_next = t2;
                    pres_next[vic_reg] = 1'b0;
                    ls_next[vic_reg] = LS_UNLOADED;
                    out_next = pack_res(1'b1, ID_W'(vic_reg), ls_reg[vic_reg],
                        LS_UNLOADED, ls_reg[vic_reg] != LS_UNLOADED, t2,
                        (max_reg != '0) && (t2 > {4'd0, max_reg}));
                    olast_next = 1'b0; ovld_next = 1'b1;
                    state_next = ST_SCAN; scan_next = '0; found_next = 1'b0;
                end
            end
            ST_ACK: begin
                if (!ovld_reg || m_axis_tready) begin
                    out_next = pack_res(1'b0, id_reg, st, st, 1'b0, total_reg, over);
                    olast_next = 1'b1; ovld_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; max_reg <= '0; total_reg <= '0; cnt_reg <= '0;
            pres_reg <= '0; ovld_reg <= 1'b0; rvld_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) ls_reg[i] <= LS_UNLOADED;
        end else begin
            state_reg <= state_next; total_reg <= total_next; cnt_reg <= cnt_next;
            pres_reg <= pres_next; ovld_reg <= ovld_next; rvld_reg <= rvld_next;
            ls_reg <= ls_next;
            if (cfg_we) max_reg <= cfg_wdata;
        end
        op_reg <= op_next; id_reg <= id_next; bc_reg <= bc_next; ns_reg <= ns_next;
        prot_reg <= prot_next; scan_reg <= scan_next; ridx_reg <= ridx_next;
        found_reg <= found_next; vic_reg <= vic_next; old_reg <= old_next;
        vbytes_reg <= vbytes_next; out_reg <= out_next; olast_reg <= olast_next;
    end

    // no loading entry is ever chosen as victim
    a_no_loading_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVICT) |-> ls_reg[vic_reg] != LS_LOADING)
        else $error("loading entry selected as victim");
    // victim must be present
    a_victim_present: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVICT) |-> pres_reg[vic_reg])
        else $error("victim not present");
    // input taken only when idle with empty output register
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> state_reg == ST_CHECK)
        else $error("accept outside idle");
endmodule

// ----- tb/bble_checker.sv -----
// Result checker for the byte-budget LRU evictor: watches both stream channels and the
// budget register, predicts every result and compares it field by field.
// Depends on bble_pkg.
module bble_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [47:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [63:0]  m_axis_tdata,
    input  logic         m_axis_tlast,
    output int           fail_count,
    output int           pending,
    output int           evict_seen
);
    import bble_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               kind;
        logic [ID_W-1:0]    rid;
        logic [LS_W-1:0]    from_st;
        logic [LS_W-1:0]    to_st;
        logic               changed;
        logic [TOTAL_W-1:0] total;
        logic               over;
        logic               last;
    } result_t;

    result_t           expected_q[$];
    logic [BYTE_W-1:0] budget;
    logic              present[16];
    logic [BYTE_W-1:0] size_tab[16];
    logic [31:0]       stamp_tab[16];
    logic [LS_W-1:0]   lstate[16];
    logic [TOTAL_W-1:0] charged;
    logic [31:0]       stamp_ctr;

    assign pending = expected_q.size();

    function automatic logic is_over();
        return budget != 0 && charged > {4'd0, budget};
    endfunction

    task automatic push_result(input logic kind, input logic [3:0] id,
                               input logic [1:0] f, input logic [1:0] t,
                               input logic ch, input logic lst);
        result_t r;
        r = '{kind, id, f, t, ch, charged, is_over(), lst};
        expected_q = {expected_q, r};
    endtask

    // Evict oldest eligible entries while over a nonzero budget; prot < 0 protects none.
    task automatic shed_bytes(input int prot);
        int victim;
        logic [1:0] old;
        if (budget == 0) return;
        while (charged > {4'd0, budget}) begin
            victim = -1;
            for (int i = 0; i < 16; i++) begin
                if (!present[i] || i == prot || lstate[i] == LS_LOADING) continue;
                if (victim < 0 || stamp_tab[i] < stamp_tab[victim]) victim = i;
            end
            if (victim < 0) break;
            charged = charged - {4'd0, size_tab[victim]};
            present[victim] = 1'b0;
            old = lstate[victim];
            lstate[victim] = LS_UNLOADED;
            push_result(1'b1, victim[3:0], old, LS_UNLOADED, old != LS_UNLOADED, 1'b0);
        end
    endtask

    task automatic apply_op(input logic [63:0] d);
        logic [2:0]        op;
        logic [3:0]        id;
        logic [BYTE_W-1:0] nbytes;
        logic [1:0]        ns;
        op = d[2:0];
        id = d[6:3];
        nbytes = d[54:7];
        ns = d[56:55];
        case (op)
            OP_TOUCH: begin
                if (present[id]) begin
                    stamp_tab[id] = stamp_ctr;
                    stamp_ctr++;
                end
            end
            OP_INSERT: begin
                stamp_tab[id] = stamp_ctr;
                stamp_ctr++;
                if (!present[id]) begin
                    present[id] = 1'b1;
                    size_tab[id] = nbytes;
                    charged = charged + {4'd0, nbytes};
                end
                shed_bytes(int'(id));
            end
            OP_SETST: begin
                if (ns <= LS_LOADED) begin
                    push_result(1'b0, id, lstate[id], ns, lstate[id] != ns, 1'b1);
                    lstate[id] = ns;
                    // the total and over flag are unaffected, so the pushed ack holds
                    expected_q[$].to_st = ns;
                    return;
                end
            end
            OP_ENFORCE: shed_bytes(-1);
            OP_CLEAR: begin
                for (int i = 0; i < 16; i++) begin
                    present[i] = 1'b0;
                    lstate[i] = LS_UNLOADED;
                end
                charged = '0;
            end
            default: ;
        endcase
        push_result(1'b0, id, lstate[id], lstate[id], 1'b0, 1'b1);
    endtask

    // Track configuration and inputs; compare each output transaction.
    always @(posedge aclk) begin
        result_t got, exp_r;
        if (!aresetn) begin
            budget = '0;
            charged = '0;
            stamp_ctr = '0;
            for (int i = 0; i < 16; i++) begin
                present[i] = 1'b0;
                lstate[i] = LS_UNLOADED;
                size_tab[i] = '0;
                stamp_tab[i] = '0;
            end
            expected_q.delete();
            fail_count <= 0;
            evict_seen <= 0;
        end else begin
            if (cfg_we) budget = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) apply_op(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[0], m_axis_tdata[4:1], m_axis_tdata[6:5],
                        m_axis_tdata[8:7], m_axis_tdata[9], m_axis_tdata[61:10],
                        m_axis_tdata[62], m_axis_tlast};
                if (got.kind) evict_seen <= evict_seen + 1;
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        fail_count <= fail_count + 1;
                        if (got.kind !== exp_r.kind)
                            $error("kind: expected %0d got %0d", exp_r.kind, got.kind);
                        if (got.rid !== exp_r.rid)
                            $error("result_id: expected %0d got %0d", exp_r.rid, got.rid);
                        if (got.from_st !== exp_r.from_st)
                            $error("from_state: expected %0d got %0d",
                                   exp_r.from_st, got.from_st);
                        if (got.to_st !== exp_r.to_st)
                            $error("to_state: expected %0d got %0d", exp_r.to_st, got.to_st);
                        if (got.changed !== exp_r.changed)
                            $error("state_changed: expected %0d got %0d",
                                   exp_r.changed, got.changed);
                        if (got.total !== exp_r.total)
                            $error("total_bytes: expected %0d got %0d",
                                   exp_r.total, got.total);
                        if (got.over !== exp_r.over)
                            $error("over_budget: expected %0d got %0d", exp_r.over, got.over);
                        if (got.last !== exp_r.last)
                            $error("last: expected %0d got %0d", exp_r.last, got.last);
                    end
                end
            end
        end
    end
endmodule

// ----- tb/tb.sv -----
// Testbench top for byte_budget_lru_evictor: clock, reset, budget phases, directed and
// random operation streams with random gaps. Depends on bble_pkg and bble_checker.
module tb;
    import bble_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [47:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count, pending, evict_seen;
    int          ops_sent = 0;
    logic        hold_sink = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    byte_budget_lru_evictor uut (.*);

    bble_checker chk (.*);

    function automatic logic [63:0] pack_op(input logic [2:0] op, input logic [3:0] id,
                                            input logic [47:0] nb, input logic [1:0] ns);
        return {7'd0, ns, nb, id, op};
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Offer one transaction and hold it until accepted.
    task automatic send_op(input logic [63:0] d);
        int g;
        g = gap_len();
        if (g != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        ops_sent++;
    endtask

    task automatic idle_sender();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_out();
        idle_sender();
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic set_budget(input logic [47:0] b);
        cfg_we <= 1'b1;
        cfg_wdata <= b;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Mostly small sizes so evictions happen often; sometimes extremes.
    function automatic logic [47:0] rand_bytes();
        case ($urandom_range(0, 9))
            0: return 48'hFFFF_FFFF_FFFF;
            1: return 48'({$urandom(), $urandom()});
            2: return 48'd0;
            default: return 48'($urandom_range(1, 300));
        endcase
    endfunction

    task automatic random_phase(input int n);
        logic [2:0] op;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: op = OP_INSERT;
                8, 9, 10: op = OP_TOUCH;
                11, 12, 13: op = OP_SETST;
                14, 15: op = OP_ENFORCE;
                16: op = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_QUERY;
                17: op = OP_QUERY;
                default: op = 3'($urandom_range(OP_QUERY, OP_RSVD7));
            endcase
            send_op(pack_op(op, 4'($urandom_range(0, 15)), rand_bytes(),
                            2'($urandom_range(0, 3))));
        end
    endtask

    // Sink readiness: random gaps, and one long hold-off on request.
    initial begin
        int g;
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_sink = 1'b0;
            end
            g = gap_len();
            if (g != 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: fill with budget off, then shrink the budget and enforce.
        send_op(pack_op(OP_QUERY, 4'd0, '0, LS_UNLOADED));
        send_op(pack_op(OP_INSERT, 4'd0, 48'd100, LS_UNLOADED));
        send_op(pack_op(OP_INSERT, 4'd1, 48'd200, LS_UNLOADED));
        send_op(pack_op(OP_INSERT, 4'd15, 48'hFFFF_FFFF_FFFF, LS_UNLOADED));
        send_op(pack_op(OP_INSERT, 4'd2, 48'd50, LS_UNLOADED));
        send_op(pack_op(OP_TOUCH, 4'd0, '0, LS_UNLOADED));
        send_op(pack_op(OP_TOUCH, 4'd9, '0, LS_UNLOADED));
        send_op(pack_op(OP_SETST, 4'd1, '0, LS_LOADING));
        send_op(pack_op(OP_SETST, 4'd2, '0, LS_LOADED));
        send_op(pack_op(OP_SETST, 4'd2, '0, LS_LOADED));
        send_op(pack_op(OP_SETST, 4'd0, '0, LS_INVALID));
        send_op(pack_op(OP_RSVD6, 4'd2, '0, LS_UNLOADED));
        send_op(pack_op(OP_RSVD7, 4'd1, 48'hFFFF_FFFF_FFFF, LS_INVALID));
        drain_out();
        set_budget(48'd150);
        send_op(pack_op(OP_ENFORCE, 4'd0, '0, LS_UNLOADED));
        send_op(pack_op(OP_INSERT, 4'd3, 48'd500, LS_UNLOADED));
        send_op(pack_op(OP_SETST, 4'd1, '0, LS_UNLOADED));
        send_op(pack_op(OP_ENFORCE, 4'd0, '0, LS_UNLOADED));
        send_op(pack_op(OP_CLEAR, 4'd0, '0, LS_UNLOADED));
        send_op(pack_op(OP_QUERY, 4'd1, '0, LS_UNLOADED));
        drain_out();
        set_budget(48'hFFFF_FFFF_FFFF);
        send_op(pack_op(OP_INSERT, 4'd4, 48'hFFFF_FFFF_FFFF, LS_UNLOADED));
        send_op(pack_op(OP_INSERT, 4'd5, 48'd1, LS_UNLOADED));
        send_op(pack_op(OP_INSERT, 4'd6, 48'hFFFF_FFFF_FFFF, LS_UNLOADED));
        drain_out();

        // Random phases across several budgets, with one long sink hold-off.
        set_budget(48'd600);
        hold_sink = 1'b1;
        random_phase(100);
        drain_out();
        set_budget(48'd1);
        random_phase(70);
        drain_out();
        set_budget(48'd0);
        random_phase(50);
        drain_out();
        set_budget(48'({$urandom(), $urandom()}));
        random_phase(60);
        drain_out();
        set_budget(48'($urandom_range(200, 1500)));
        random_phase(100);
        drain_out();

        $display("Sent %0d operations over several budget settings; %0d evictions observed.",
                 ops_sent, evict_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
